[design/iou_overlap_box_filter_defines.svh]
// Assertion macros for the IoU overlap box filter.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef IOU_OVERLAP_BOX_FILTER_DEFINES_SVH
`define IOU_OVERLAP_BOX_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define IOU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IOU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define IOU_ASSERT_NOW(lbl, pre, post, msg)
`define IOU_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[design/iou_pkg.sv]
// Shared constants and types for the IoU overlap box filter.
// No dependencies; imported by the top level.
package iou_pkg;

  localparam int MAX_BOXES     = 32;
  localparam int COORD_BITS    = 12;
  localparam int CNT_BITS      = $clog2(MAX_BOXES + 1);
  localparam int IDX_BITS      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BOX_BITS      = 4 * COORD_BITS;
  localparam int AREA_BITS     = 2 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((BOX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_LOAD_ACC = 2'd1,
    KIND_LOAD_REJ = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_t;

  // Box as stored: x in the lowest bits, then y, w, h.
  typedef struct packed {
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } box_t;

endpackage

[design/iou_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the box stores of the IoU overlap box filter.
module iou_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_BITS-1:0]  waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [ADDR_BITS-1:0]  raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/iou_overlap_box_filter.sv]
// Channel   Signals                          Contents
// in        in_tvalid/in_tready/in_tdata     box: left, top, width, height
//           in_tuser                         kind: clear, load accept, load reject, query
// out       out_tvalid/out_tready/out_tdata  keep, accepted
//
// A clear or a load finishes in the cycle of its transfer; its result sits in the output
// register from the next cycle. A query reads the accept store, then the reject store, one
// box per cycle into the single comparison pipeline, and gives its result once that pipeline
// has drained. After reset both counts are zero; the box stores hold
// whatever they held and need no clearing pass. A stalled output holds its result and keeps
// in_tready low, so no new item is taken until that result leaves.
`include "iou_overlap_box_filter_defines.svh"

module iou_overlap_box_filter
  import iou_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // left, top, width, height
  input  logic [1:0]               in_tuser,   // kind
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata   // keep, accepted, zero pad
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              st_r, st_nxt;
  logic [CNT_BITS-1:0] acnt_r, acnt_nxt;
  logic [CNT_BITS-1:0] rcnt_r, rcnt_nxt;
  logic [CNT_BITS-1:0] idx_r, idx_nxt;
  logic                sel_r, sel_nxt;
  logic                hit_acc_r, hit_acc_nxt;
  logic                hit_rej_r, hit_rej_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_keep_r, out_keep_nxt;
  logic                out_accepted_r, out_accepted_nxt;

  logic   in_fire, out_free;
  kind_t  kind;
  box_t   in_box;
  logic   acc_we, rej_we, acc_re, rej_re;
  logic   acc_full, rej_full;
  logic [BOX_BITS-1:0] acc_rdata, rej_rdata;

  // Query box, held for the whole scan.
  logic [COORD_BITS-1:0] q_x_r, q_y_r;
  logic [COORD_BITS:0]   q_xe_r, q_ye_r;
  logic [AREA_BITS-1:0]  q_area_r;

  // Comparison pipeline: read, overlap, products, compare.
  logic                  v0_r, t0_r;
  logic                  v1_r, t1_r, ovl1_r;
  logic [COORD_BITS-1:0] ow1_r, oh1_r, bw1_r, bh1_r;
  logic                  v2_r, t2_r, ovl2_r;
  logic [AREA_BITS-1:0]  inter2_r, barea2_r;

  box_t                  rd_box;
  logic [COORD_BITS:0]   b_xe, b_ye, min_xe, min_ye, ow_full, oh_full;
  logic [COORD_BITS-1:0] max_x, max_y;
  logic                  ovl_x, ovl_y;
  logic [AREA_BITS+1:0]  lhs, rhs;
  logic                  match;

  assign kind      = kind_t'(in_tuser);
  assign in_box    = box_t'(in_tdata[BOX_BITS-1:0]);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign acc_full  = (acnt_r >= CNT_BITS'(MAX_BOXES));
  assign rej_full  = (rcnt_r >= CNT_BITS'(MAX_BOXES));
  assign acc_we    = in_fire && (kind == KIND_LOAD_ACC) && !acc_full;
  assign rej_we    = in_fire && (kind == KIND_LOAD_REJ) && !rej_full;
  assign acc_re    = (st_r == S_SCAN) && !sel_r && (idx_r < acnt_r);
  assign rej_re    = (st_r == S_SCAN) && sel_r && (idx_r < rcnt_r);

  iou_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acnt_r[IDX_BITS-1:0]),
    .wdata (in_box),
    .re    (acc_re),
    .raddr (idx_r[IDX_BITS-1:0]),
    .rdata (acc_rdata)
  );

  iou_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_rej_ram (
    .clk   (clk),
    .we    (rej_we),
    .waddr (rcnt_r[IDX_BITS-1:0]),
    .wdata (in_box),
    .re    (rej_re),
    .raddr (idx_r[IDX_BITS-1:0]),
    .rdata (rej_rdata)
  );

  // Overlap extents against the box just read.
  always_comb begin
    rd_box  = box_t'(t0_r ? rej_rdata : acc_rdata);
    b_xe    = {1'b0, rd_box.x} + {1'b0, rd_box.w};
    b_ye    = {1'b0, rd_box.y} + {1'b0, rd_box.h};
    min_xe  = (q_xe_r < b_xe) ? q_xe_r : b_xe;
    min_ye  = (q_ye_r < b_ye) ? q_ye_r : b_ye;
    max_x   = (q_x_r > rd_box.x) ? q_x_r : rd_box.x;
    max_y   = (q_y_r > rd_box.y) ? q_y_r : rd_box.y;
    ovl_x   = min_xe > {1'b0, max_x};
    ovl_y   = min_ye > {1'b0, max_y};
    ow_full = min_xe - {1'b0, max_x};
    oh_full = min_ye - {1'b0, max_y};
  end

  // 2*inter > qarea + barea - inter, rearranged as 3*inter > qarea + barea.
  assign lhs   = {1'b0, inter2_r, 1'b0} + {2'b00, inter2_r};
  assign rhs   = {2'b00, q_area_r} + {2'b00, barea2_r};
  assign match = v2_r && ovl2_r && (lhs > rhs);

  always_ff @(posedge clk) begin
    v0_r     <= acc_re || rej_re;
    t0_r     <= sel_r;
    v1_r     <= v0_r;
    t1_r     <= t0_r;
    ovl1_r   <= ovl_x && ovl_y;
    ow1_r    <= ow_full[COORD_BITS-1:0];
    oh1_r    <= oh_full[COORD_BITS-1:0];
    bw1_r    <= rd_box.w;
    bh1_r    <= rd_box.h;
    v2_r     <= v1_r;
    t2_r     <= t1_r;
    ovl2_r   <= ovl1_r;
    inter2_r <= AREA_BITS'(ow1_r) * AREA_BITS'(oh1_r);
    barea2_r <= AREA_BITS'(bw1_r) * AREA_BITS'(bh1_r);
    if (in_fire && (kind == KIND_QUERY)) begin
      q_x_r    <= in_box.x;
      q_y_r    <= in_box.y;
      q_xe_r   <= {1'b0, in_box.x} + {1'b0, in_box.w};
      q_ye_r   <= {1'b0, in_box.y} + {1'b0, in_box.h};
      q_area_r <= AREA_BITS'(in_box.w) * AREA_BITS'(in_box.h);
    end
  end

  always_comb begin
    st_nxt           = st_r;
    acnt_nxt         = acnt_r;
    rcnt_nxt         = rcnt_r;
    idx_nxt          = idx_r;
    sel_nxt          = sel_r;
    hit_acc_nxt      = hit_acc_r || (match && !t2_r);
    hit_rej_nxt      = hit_rej_r || (match && t2_r);
    out_valid_nxt    = out_valid_r && !out_tready;
    out_keep_nxt     = out_keep_r;
    out_accepted_nxt = out_accepted_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          out_keep_nxt     = 1'b0;
          out_accepted_nxt = acc_we || rej_we;
          unique case (kind)
            KIND_CLEAR: begin
              acnt_nxt      = '0;
              rcnt_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            KIND_LOAD_ACC: begin
              if (acc_we) begin
                acnt_nxt = acnt_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            KIND_LOAD_REJ: begin
              if (rej_we) begin
                rcnt_nxt = rcnt_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            KIND_QUERY: begin
              idx_nxt     = '0;
              sel_nxt     = 1'b0;
              hit_acc_nxt = 1'b0;
              hit_rej_nxt = 1'b0;
              st_nxt      = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (acc_re || rej_re) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!sel_r) begin
          sel_nxt = 1'b1;
          idx_nxt = '0;
        end else begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v0_r && !v1_r && !v2_r) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_keep_nxt     = hit_acc_r && !hit_rej_r;
          out_accepted_nxt = 1'b0;
          st_nxt           = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      acnt_r      <= '0;
      rcnt_r      <= '0;
      idx_r       <= '0;
      sel_r       <= 1'b0;
      hit_acc_r   <= 1'b0;
      hit_rej_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      acnt_r      <= acnt_nxt;
      rcnt_r      <= rcnt_nxt;
      idx_r       <= idx_nxt;
      sel_r       <= sel_nxt;
      hit_acc_r   <= hit_acc_nxt;
      hit_rej_r   <= hit_rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_keep_r     <= out_keep_nxt;
    out_accepted_r <= out_accepted_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS - 2){1'b0}}, out_accepted_r, out_keep_r};

  `IOU_ASSERT_NOW(a_cnt_bound, 1'b1,
    (acnt_r <= CNT_BITS'(MAX_BOXES)) && (rcnt_r <= CNT_BITS'(MAX_BOXES)),
    "box count exceeds store depth")
  `IOU_ASSERT_NEXT(a_cnt_stable_in_query, st_r != S_IDLE,
    $stable(acnt_r) && $stable(rcnt_r), "box count changed during a query")
  `IOU_ASSERT_NOW(a_pipe_in_query, v0_r || v1_r || v2_r,
    (st_r == S_SCAN) || (st_r == S_DRAIN), "comparison pipeline busy outside a query")
  `IOU_ASSERT_NOW(a_result_kind, out_valid_r, !(out_keep_r && out_accepted_r),
    "result flags both keep and accepted")

endmodule
